### sv/rgb_colour_classifier_macros.svh
// rgb_colour_classifier_macros.svh: assertion macros for the colour classifier
// no dependencies; included by the port checker
`ifndef RGB_COLOUR_CLASSIFIER_MACROS_SVH
`define RGB_COLOUR_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define RCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("colour classifier check failed");

// next-cycle implication, disabled while rst is high
`define RCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("colour classifier check failed");

`endif

### sv/rcc_pkg.sv
// rcc_pkg: types, colour codes, register indexes and pattern table
// for the rgb colour classifier; no dependencies
package rcc_pkg;

   typedef logic [2:0] colour_type;
   typedef logic [1:0] csr_addr_type;
   typedef logic [6:0] pct_type;

   // colour codes
   localparam colour_type COLOUR_NONE   = 3'd0;
   localparam colour_type COLOUR_YELLOW = 3'd1;
   localparam colour_type COLOUR_GREEN  = 3'd2;
   localparam colour_type COLOUR_BLUE   = 3'd3;
   localparam colour_type COLOUR_ORANGE = 3'd4;
   localparam colour_type COLOUR_PURPLE = 3'd5;

   // register indexes
   localparam csr_addr_type CSR_TOLERANCE = 2'd0;
   localparam csr_addr_type CSR_LUM_LOW   = 2'd1;
   localparam csr_addr_type CSR_LUM_HIGH  = 2'd2;

   // register widths and reset values
   localparam int TOL_W  = 6;
   localparam int LUM_W  = 16;
   localparam int CSR_W  = 16;
   localparam logic [TOL_W-1:0] TOL_RESET      = 6'd10;
   localparam logic [LUM_W-1:0] LUM_LOW_RESET  = 16'd5177;
   localparam logic [LUM_W-1:0] LUM_HIGH_RESET = 16'd9109;

   // luminance weights, q16, summing to 65536
   localparam logic [15:0] LUM_WR = 16'd13933;
   localparam logic [15:0] LUM_WG = 16'd46871;
   localparam logic [15:0] LUM_WB = 16'd4732;

   localparam pct_type PCT_FULL = 7'd100;

   // reference patterns in priority order, percent of the largest channel (r, g, b)
   localparam int NUM_PATTERNS = 5;
   localparam int NUM_CHANNELS = 3;
   localparam int PAT_PURPLE   = 4;
   localparam pct_type PAT_TABLE [NUM_PATTERNS][NUM_CHANNELS] = '{
      '{7'd100, 7'd56,  7'd27},
      '{7'd44,  7'd100, 7'd49},
      '{7'd66,  7'd88,  7'd100},
      '{7'd100, 7'd15,  7'd14},
      '{7'd100, 7'd30,  7'd30}
   };
   localparam colour_type PAT_CODE [NUM_PATTERNS] = '{
      COLOUR_YELLOW, COLOUR_GREEN, COLOUR_BLUE, COLOUR_ORANGE, COLOUR_PURPLE
   };

endpackage

### sv/rgb_colour_classifier.sv
// rgb_colour_classifier: classifies rgb sensor samples against five colour patterns
// depends on rcc_pkg
// an accepted item passes through the input, product and result registers before its result is valid
// throughput: one item per cycle while results are taken; each stage holds one item and moves on when the next is free
// items with sample_ok low are dropped at the input and give no result
// reset (synchronous, active high): pipeline empty, last colour none, registers at defaults
module rgb_colour_classifier #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // input item
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [47:0]                req_tdata,   // red_level, green_level, blue_level
   input  logic                       req_tuser,   // sample_ok
   // result item
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // colour_code, colour_changed, zero pad
   // register writes
   input  logic                       csr_we,
   input  rcc_pkg::csr_addr_type      csr_addr,
   input  logic [rcc_pkg::CSR_W-1:0]  csr_wdata
);
   import rcc_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int SCL_W = SB + 7;    // 100 * channel
   localparam int TM_W  = SB + 6;    // tolerance * max
   localparam int CMP_W = SB + 8;    // compare width, holds sums of the above
   localparam int SUM_W = SB + 16;   // weighted luminance sum

   // configuration registers
   logic [TOL_W-1:0] tol_ff;
   logic [LUM_W-1:0] lum_low_ff, lum_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff      <= TOL_RESET;
         lum_low_ff  <= LUM_LOW_RESET;
         lum_high_ff <= LUM_HIGH_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TOLERANCE: tol_ff      <= csr_wdata[TOL_W-1:0];
            CSR_LUM_LOW:   lum_low_ff  <= csr_wdata[LUM_W-1:0];
            CSR_LUM_HIGH:  lum_high_ff <= csr_wdata[LUM_W-1:0];
            default: ;
         endcase
      end
   end

   // stage handshake: a stage loads when it is empty or its item moves on
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_rdy, s2_rdy, s1_rdy;

   assign out_rdy    = !rsp_valid_ff || rsp_tready;
   assign s2_rdy     = !s2_valid_ff || out_rdy;
   assign s1_rdy     = !s1_valid_ff || s2_rdy;
   assign req_tready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy)  s1_valid_ff  <= req_tvalid && req_tuser;
         if (s2_rdy)  s2_valid_ff  <= s1_valid_ff;
         if (out_rdy) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // input register, low sample bits of each channel
   logic [SB-1:0] s1_ch_ff [NUM_CHANNELS];

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_ch_ff[0] <= req_tdata[SB-1:0];
         s1_ch_ff[1] <= req_tdata[16+SB-1:16];
         s1_ch_ff[2] <= req_tdata[32+SB-1:32];
      end
   end

   // max channel, tolerance times max, scaled channels and luminance
   logic [SB-1:0]    mx_in;
   logic [TM_W-1:0]  tol_mx_in;
   logic [SCL_W-1:0] scl_in [NUM_CHANNELS];
   logic [SUM_W-1:0] lum_sum;
   logic [LUM_W-1:0] lum_in;

   always_comb begin
      mx_in = s1_ch_ff[0];
      if (s1_ch_ff[1] > mx_in) mx_in = s1_ch_ff[1];
      if (s1_ch_ff[2] > mx_in) mx_in = s1_ch_ff[2];
      tol_mx_in = TM_W'(mx_in) * TM_W'(tol_ff);
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         scl_in[c] = SCL_W'(s1_ch_ff[c]) * SCL_W'(PCT_FULL);
      end
      lum_sum = SUM_W'(s1_ch_ff[0]) * SUM_W'(LUM_WR)
              + SUM_W'(s1_ch_ff[1]) * SUM_W'(LUM_WG)
              + SUM_W'(s1_ch_ff[2]) * SUM_W'(LUM_WB);
      lum_in = lum_sum[SUM_W-1:SB];
   end

   logic [SB-1:0]    s2_mx_ff;
   logic [TM_W-1:0]  s2_tol_mx_ff;
   logic [SCL_W-1:0] s2_scl_ff [NUM_CHANNELS];
   logic [LUM_W-1:0] s2_lum_ff;

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_mx_ff     <= mx_in;
         s2_tol_mx_ff <= tol_mx_in;
         s2_scl_ff    <= scl_in;
         s2_lum_ff    <= lum_in;
      end
   end

   // pattern tests: (e-tol)*max <= 100*ch <= (e+tol)*max, rearranged to stay unsigned
   logic [NUM_PATTERNS-1:0] pat_hit;
   logic [CMP_W-1:0]        exp_mx, scl_w, tm_w;
   logic                    lum_ok;
   colour_type              code_in;
   logic                    changed_in;
   colour_type              last_colour_ff;

   always_comb begin
      exp_mx = '0;
      scl_w  = '0;
      tm_w   = CMP_W'(s2_tol_mx_ff);
      for (int k = 0; k < NUM_PATTERNS; k++) begin
         pat_hit[k] = 1'b1;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            exp_mx = CMP_W'(s2_mx_ff) * CMP_W'(PAT_TABLE[k][c]);
            scl_w  = CMP_W'(s2_scl_ff[c]);
            if (scl_w + tm_w < exp_mx || scl_w > exp_mx + tm_w) pat_hit[k] = 1'b0;
         end
      end
      lum_ok = (s2_lum_ff >= lum_low_ff) && (s2_lum_ff <= lum_high_ff);

      // priority order, all-zero sample is none
      priority if (s2_mx_ff == '0)                 code_in = COLOUR_NONE;
      else if (pat_hit[0])                         code_in = PAT_CODE[0];
      else if (pat_hit[1])                         code_in = PAT_CODE[1];
      else if (pat_hit[2])                         code_in = PAT_CODE[2];
      else if (pat_hit[3])                         code_in = PAT_CODE[3];
      else if (pat_hit[PAT_PURPLE] && lum_ok)      code_in = PAT_CODE[PAT_PURPLE];
      else                                         code_in = COLOUR_NONE;

      changed_in = (code_in != last_colour_ff);
   end

   // result register and last colour
   colour_type rsp_code_ff;
   logic       rsp_changed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_colour_ff <= COLOUR_NONE;
      end else if (out_rdy && s2_valid_ff) begin
         last_colour_ff <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_code_ff    <= code_in;
         rsp_changed_ff <= changed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_changed_ff, rsp_code_ff};

endmodule

### sv/rcc_port_checker.sv
// rcc_port_checker: port-level checks on the rgb colour classifier, bound to the top level
// depends on rcc_pkg and rgb_colour_classifier_macros.svh
`include "rgb_colour_classifier_macros.svh"

module rcc_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import rcc_pkg::*;

   logic       rsp_fire;
   logic       rsp_stall;
   colour_type rsp_code;
   logic       rsp_changed;
   logic       rsp_well_formed;
   logic       prev_fire_ff;
   colour_type prev_code_ff;
   logic       back_to_back;
   logic       flag_ok;

   assign rsp_fire        = rsp_tvalid && rsp_tready;
   assign rsp_stall       = rsp_tvalid && !rsp_tready;
   assign rsp_code        = rsp_tdata[2:0];
   assign rsp_changed     = rsp_tdata[3];
   assign rsp_well_formed = (rsp_code <= COLOUR_PURPLE) && (rsp_tdata[7:4] == 4'b0000);

   // registered copies of the result accept and the result code; the code is captured even when no result is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_fire_ff <= 1'b0;
      end else begin
         prev_fire_ff <= rsp_fire;
      end
      prev_code_ff <= rsp_code;
   end

   assign back_to_back = rsp_fire && prev_fire_ff;
   assign flag_ok      = (rsp_changed == (rsp_code != prev_code_ff));

   // a stalled result item holds
   `RCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // reset leaves no result pending
   `RCC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // code stays in the defined range and the pad bits are zero
   `RCC_ASSERT_IMPLY(a_code_range, clock, reset, rsp_tvalid, rsp_well_formed)

   // on back-to-back results the change flag compares with the previous code
   `RCC_ASSERT_IMPLY(a_change_flag, clock, reset, back_to_back, flag_ok)

endmodule

bind rgb_colour_classifier rcc_port_checker u_rcc_port_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
